/* rtl/hslr_pkg.sv */
// ----------------------------------------------------------------------------
// hslr_pkg
// Shared widths, constants and stage types for the HSL to RGB565 pipeline.
// ----------------------------------------------------------------------------
package hslr_pkg;

    localparam int unsigned FRACTION_BITS = 8;

    localparam int unsigned IN_W    = 9;
    localparam int unsigned PIX_W   = 16;
    localparam int unsigned ONE     = 1 << FRACTION_BITS;
    localparam int unsigned ONE_W   = FRACTION_BITS + 1;
    localparam int unsigned CN_W    = 2 * FRACTION_BITS + 1;
    localparam int unsigned NUM_W   = CN_W + 9;
    localparam int unsigned COEF_W  = 8;
    localparam int unsigned RAMP_W  = 6;
    localparam int unsigned OFS_W   = 7;
    localparam int unsigned V_W     = 11;
    localparam int unsigned V_SHIFT = 2 * FRACTION_BITS - 3;
    localparam int unsigned Q_W     = 8;
    localparam int unsigned NST     = 4;

    localparam logic [IN_W-1:0]  HUE_WRAP   = IN_W'(360);
    localparam logic [IN_W-1:0]  HUE_SECTOR = IN_W'(60);
    localparam logic [OFS_W-1:0] HUE_PAIR   = OFS_W'(120);
    localparam logic [OFS_W-1:0] HUE_HALF   = OFS_W'(60);

    localparam logic signed [COEF_W-1:0] COEF_FULL = COEF_W'(60);
    localparam logic signed [COEF_W-1:0] COEF_NONE = -COEF_W'(60);

    // floor(v / 15) = (v * RECIP_15) >> RECIP_SHIFT for v below 2^V_W
    localparam logic [12:0] RECIP_15    = 13'd4370;
    localparam int unsigned RECIP_SHIFT = 16;

    localparam logic [4:0] MAX_RB = 5'd31;
    localparam logic [5:0] MAX_G  = 6'd63;

    typedef enum logic [2:0] {
        SEC_RED_YEL,
        SEC_YEL_GRN,
        SEC_GRN_CYN,
        SEC_CYN_BLU,
        SEC_BLU_MAG,
        SEC_MAG_RED
    } t_sector;

    typedef struct packed {
        logic [ONE_W-1:0]  span;
        logic [ONE_W-1:0]  sat;
        logic [ONE_W-1:0]  light;
        t_sector           sector;
        logic [RAMP_W-1:0] ramp;
    } t_prep;

    typedef struct packed {
        logic [CN_W-1:0]   cn;
        logic [ONE_W-1:0]  light;
        t_sector           sector;
        logic [RAMP_W-1:0] ramp;
    } t_chroma;

    typedef struct packed {
        logic [V_W-1:0] red;
        logic [V_W-1:0] grn;
        logic [V_W-1:0] blu;
    } t_chan;

endpackage

/* rtl/hslr_if.sv */
// ----------------------------------------------------------------------------
// hslr_if
// Request channels of the HSL to RGB565 pipeline.
// ----------------------------------------------------------------------------
interface hslr_in_if import hslr_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] hue;
    logic [IN_W-1:0] saturation;
    logic [IN_W-1:0] lightness;

    modport source (output valid, hue, saturation, lightness, input ready);
    modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

interface hslr_out_if import hslr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_color;

    modport source (output valid, pixel_color, input ready);
    modport sink   (input valid, pixel_color, output ready);
endinterface

/* rtl/hslr_prep.sv */
// ----------------------------------------------------------------------------
// hslr_prep
// Stage 1: input clamping, hue sector, ramp position and chroma span.
// ----------------------------------------------------------------------------
module hslr_prep import hslr_pkg::*; (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [IN_W-1:0] i_hue,
    input  logic [IN_W-1:0] i_sat,
    input  logic [IN_W-1:0] i_light,
    output t_prep           o_prep
);

    logic [IN_W-1:0]  hue_w;
    logic [31:0]      sat32;
    logic [31:0]      light32;
    logic [ONE_W-1:0] sat_c;
    logic [ONE_W-1:0] light_c;
    logic [ONE_W:0]   twol;
    logic [ONE_W:0]   l_dev;
    t_sector          sector;
    logic [IN_W-1:0]  pair_base;
    logic [OFS_W-1:0] ofs;
    logic [OFS_W-1:0] ramp;
    t_prep            n_prep;
    t_prep            r_prep;

    always_comb begin
        hue_w   = (i_hue >= HUE_WRAP) ? i_hue - HUE_WRAP : i_hue;
        sat32   = 32'(i_sat);
        light32 = 32'(i_light);
        sat_c   = (sat32 > ONE) ? ONE_W'(ONE) : ONE_W'(sat32);
        light_c = (light32 > ONE) ? ONE_W'(ONE) : ONE_W'(light32);

        twol  = {light_c, 1'b0};
        l_dev = (twol >= (ONE_W + 1)'(ONE)) ? twol - (ONE_W + 1)'(ONE)
                                            : (ONE_W + 1)'(ONE) - twol;

        if (hue_w < HUE_SECTOR) begin
            sector = SEC_RED_YEL;
        end else if (hue_w < IN_W'(2) * HUE_SECTOR) begin
            sector = SEC_YEL_GRN;
        end else if (hue_w < IN_W'(3) * HUE_SECTOR) begin
            sector = SEC_GRN_CYN;
        end else if (hue_w < IN_W'(4) * HUE_SECTOR) begin
            sector = SEC_CYN_BLU;
        end else if (hue_w < IN_W'(5) * HUE_SECTOR) begin
            sector = SEC_BLU_MAG;
        end else begin
            sector = SEC_MAG_RED;
        end

        case (sector)
            SEC_RED_YEL, SEC_YEL_GRN: pair_base = '0;
            SEC_GRN_CYN, SEC_CYN_BLU: pair_base = IN_W'(HUE_PAIR);
            default:                  pair_base = IN_W'(2) * IN_W'(HUE_PAIR);
        endcase

        ofs  = OFS_W'(hue_w - pair_base);
        ramp = (ofs >= HUE_HALF) ? HUE_PAIR - ofs : ofs;

        n_prep.span   = ONE_W'(ONE) - l_dev[ONE_W-1:0];
        n_prep.sat    = sat_c;
        n_prep.light  = light_c;
        n_prep.sector = sector;
        n_prep.ramp   = ramp[RAMP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prep <= n_prep;
        end
    end

    assign o_prep = r_prep;

endmodule

/* rtl/hslr_chroma.sv */
// ----------------------------------------------------------------------------
// hslr_chroma
// Stage 2: chroma product of span and saturation.
// ----------------------------------------------------------------------------
module hslr_chroma import hslr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_prep   i_prep,
    output t_chroma o_chroma
);

    logic [2*ONE_W-1:0] prod;
    t_chroma            n_chroma;
    t_chroma            r_chroma;

    always_comb begin
        prod            = (2 * ONE_W)'(i_prep.span) * (2 * ONE_W)'(i_prep.sat);
        n_chroma.cn     = prod[CN_W-1:0];
        n_chroma.light  = i_prep.light;
        n_chroma.sector = i_prep.sector;
        n_chroma.ramp   = i_prep.ramp;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_chroma <= n_chroma;
        end
    end

    assign o_chroma = r_chroma;

endmodule

/* rtl/hslr_mix.sv */
// ----------------------------------------------------------------------------
// hslr_mix
// Stage 3: per-channel sum of lightness term and weighted chroma, pre-scaled.
// ----------------------------------------------------------------------------
module hslr_mix import hslr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_chroma i_chroma,
    output t_chan   o_chan
);

    logic [ONE_W+6:0]           l120;
    logic signed [NUM_W-1:0]    lterm;
    logic signed [CN_W:0]       cn_s;
    logic signed [COEF_W-1:0]   c_ramp;
    logic signed [COEF_W-1:0]   c_r;
    logic signed [COEF_W-1:0]   c_g;
    logic signed [COEF_W-1:0]   c_b;
    logic signed [NUM_W-1:0]    num_r;
    logic signed [NUM_W-1:0]    num_g;
    logic signed [NUM_W-1:0]    num_b;
    t_chan                      n_chan;
    t_chan                      r_chan;

    // channel = 120*L*ONE + cn*(2k - 60), k being 60, ramp or 0
    always_comb begin
        l120   = (ONE_W + 7)'(i_chroma.light) * (ONE_W + 7)'(HUE_PAIR);
        lterm  = $signed(NUM_W'({l120, {FRACTION_BITS{1'b0}}}));
        cn_s   = $signed({1'b0, i_chroma.cn});
        c_ramp = $signed({1'b0, i_chroma.ramp, 1'b0}) - COEF_FULL;

        case (i_chroma.sector)
            SEC_RED_YEL: begin c_r = COEF_FULL; c_g = c_ramp;    c_b = COEF_NONE; end
            SEC_YEL_GRN: begin c_r = c_ramp;    c_g = COEF_FULL; c_b = COEF_NONE; end
            SEC_GRN_CYN: begin c_r = COEF_NONE; c_g = COEF_FULL; c_b = c_ramp;    end
            SEC_CYN_BLU: begin c_r = COEF_NONE; c_g = c_ramp;    c_b = COEF_FULL; end
            SEC_BLU_MAG: begin c_r = c_ramp;    c_g = COEF_NONE; c_b = COEF_FULL; end
            default:     begin c_r = COEF_FULL; c_g = COEF_NONE; c_b = c_ramp;    end
        endcase

        num_r = lterm + cn_s * c_r;
        num_g = lterm + cn_s * c_g;
        num_b = lterm + cn_s * c_b;

        n_chan.red = num_r[V_SHIFT +: V_W];
        n_chan.grn = num_g[V_SHIFT +: V_W];
        n_chan.blu = num_b[V_SHIFT +: V_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_chan <= n_chan;
        end
    end

    assign o_chan = r_chan;

endmodule

/* rtl/hslr_pack.sv */
// ----------------------------------------------------------------------------
// hslr_pack
// Stage 4: divide by 15, saturate each channel and pack RGB565.
// ----------------------------------------------------------------------------
module hslr_pack import hslr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  t_chan            i_chan,
    output logic [PIX_W-1:0] o_pixel
);

    logic [23:0]      p_r;
    logic [23:0]      p_g;
    logic [23:0]      p_b;
    logic [Q_W-1:0]   q_r;
    logic [Q_W-1:0]   q_g;
    logic [Q_W-1:0]   q_b;
    logic [4:0]       red;
    logic [5:0]       grn;
    logic [4:0]       blu;
    logic [PIX_W-1:0] n_pixel;
    logic [PIX_W-1:0] r_pixel;

    // q = floor(v / 15) is the 64-scaled level; red and blue take q / 2
    always_comb begin
        p_r = 24'(i_chan.red) * 24'(RECIP_15);
        p_g = 24'(i_chan.grn) * 24'(RECIP_15);
        p_b = 24'(i_chan.blu) * 24'(RECIP_15);
        q_r = p_r[RECIP_SHIFT +: Q_W];
        q_g = p_g[RECIP_SHIFT +: Q_W];
        q_b = p_b[RECIP_SHIFT +: Q_W];

        red = (q_r[Q_W-1:1] > Q_W'(MAX_RB) >> 0) ? MAX_RB : q_r[5:1];
        grn = (q_g > Q_W'(MAX_G)) ? MAX_G : q_g[5:0];
        blu = (q_b[Q_W-1:1] > Q_W'(MAX_RB) >> 0) ? MAX_RB : q_b[5:1];

        n_pixel = {red, grn, blu};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_pixel = r_pixel;

endmodule

/* rtl/hsl_to_rgb565.sv */
// An accepted request moves through the prep, chroma, mix and pack registers to o_px.
// Throughput: one request per cycle while o_px is ready; the four stages each hold one request.
// A stalled output holds its stage; earlier stages keep filling any bubbles.
// Reset (synchronous, active low) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// hsl_to_rgb565
// HSL to RGB565 colour conversion, four-stage pipeline.
// ----------------------------------------------------------------------------
module hsl_to_rgb565 import hslr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hslr_in_if.sink     i_px,
    hslr_out_if.source  o_px
);

    logic [NST-1:0] r_v;
    logic [NST-1:0] n_v;
    logic [NST-1:0] stage_en;
    t_prep          prep;
    t_chroma        chroma;
    t_chan          chan;

    always_comb begin
        stage_en[NST-1] = !r_v[NST-1] || o_px.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            stage_en[k] = !r_v[k] || stage_en[k+1];
        end
        n_v = r_v;
        if (stage_en[0]) begin
            n_v[0] = i_px.valid;
        end
        for (int k = 1; k < NST; k++) begin
            if (stage_en[k]) begin
                n_v[k] = r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign i_px.ready = stage_en[0];
    assign o_px.valid = r_v[NST-1];

    hslr_prep u_prep (
        .i_clk   (i_clk),
        .i_en    (stage_en[0]),
        .i_hue   (i_px.hue),
        .i_sat   (i_px.saturation),
        .i_light (i_px.lightness),
        .o_prep  (prep)
    );

    hslr_chroma u_chroma (
        .i_clk    (i_clk),
        .i_en     (stage_en[1]),
        .i_prep   (prep),
        .o_chroma (chroma)
    );

    hslr_mix u_mix (
        .i_clk    (i_clk),
        .i_en     (stage_en[2]),
        .i_chroma (chroma),
        .o_chan   (chan)
    );

    hslr_pack u_pack (
        .i_clk   (i_clk),
        .i_en    (stage_en[3]),
        .i_chan  (chan),
        .o_pixel (o_px.pixel_color)
    );

`ifndef ASSERT_OFF
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_px.valid && i_px.ready) |=> r_v[0])
        else $error("accepted request not captured in first stage");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[1] && !stage_en[2]) |=> r_v[1])
        else $error("stalled stage dropped its request");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v == {NST{1'b1}} && !o_px.ready) |-> !i_px.ready)
        else $error("full pipeline accepted a request while stalled");

    a_out_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NST-2] && !o_px.valid) |=> o_px.valid)
        else $error("request not advanced into empty output stage");
`endif

endmodule
